[sv/rfcd_pkg.sv]
// Shared types, constants and CRC functions for the frame CRC and de-whitening checker.
package rfcd_pkg;

   localparam int WHITEN_DEPTH    = 64;
   localparam int MAX_FRAME_BYTES = 255;
   localparam int WADDR_W         = (WHITEN_DEPTH > 1) ? $clog2(WHITEN_DEPTH) : 1;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   // crc_mode codes
   localparam logic [1:0] CRC_NONE   = 2'd0;
   localparam logic [1:0] CRC_8      = 2'd1;
   localparam logic [1:0] CRC_CCITT0 = 2'd2;
   localparam logic [1:0] CRC_CCITT1 = 2'd3;

   // input commands
   localparam logic CMD_FRAME = 1'b0;
   localparam logic CMD_TABLE = 1'b1;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // frame status codes
   localparam logic [1:0] STAT_OK      = 2'd0;
   localparam logic [1:0] STAT_CRC_BAD = 2'd1;
   localparam logic [1:0] STAT_SHORT   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_CRC_MODE    = 2'd0;
   localparam logic [1:0] REG_WHITEN_EN   = 2'd1;
   localparam logic [1:0] REG_PAYLOAD_OFS = 2'd2;
   localparam logic [1:0] REG_ADDR_PFX_EN = 2'd3;

   localparam logic [1:0] CRC_MODE_RESET = CRC_CCITT1;

   typedef struct packed {
      logic [1:0] crc_mode;
      logic       whiten_enable;
      logic [3:0] hdr_skip;
      logic       address_prefix_enable;
   } cfg_type;

   // One queued work entry; a table write reuses value and index.
   typedef struct packed {
      logic       is_write;
      logic       has_pay;
      logic       has_stat;
      logic       whiten;
      logic [7:0] value;
      logic [7:0] index;
      logic [7:0] length;
      logic [1:0] status;
   } qent_type;

   function automatic logic [15:0] ccitt_byte(input logic [15:0] c, input logic [7:0] b);
      logic [15:0] r;
      r = c ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         r = r[15] ? ({r[14:0], 1'b0} ^ 16'h1021) : {r[14:0], 1'b0};
      end
      return r;
   endfunction

   function automatic logic [7:0] crc8_byte(input logic [7:0] c, input logic [7:0] b);
      logic [7:0] r;
      r = c ^ b;
      for (int k = 0; k < 8; k++) begin
         r = r[7] ? ({r[6:0], 1'b0} ^ 8'h07) : {r[6:0], 1'b0};
      end
      return r;
   endfunction

   localparam logic [15:0] SEED_PFX_0000 =
      ccitt_byte(ccitt_byte(ccitt_byte(16'h0000, 8'h31), 8'hFA), 8'hB6);
   localparam logic [15:0] SEED_PFX_FFFF =
      ccitt_byte(ccitt_byte(ccitt_byte(16'hFFFF, 8'h31), 8'hFA), 8'hB6);

   function automatic logic [15:0] crc_seed(input logic [1:0] mode, input logic pfx);
      logic [15:0] s;
      case (mode)
         CRC_NONE:   s = 16'h0000;
         CRC_8:      s = 16'h0071;
         CRC_CCITT0: s = pfx ? SEED_PFX_0000 : 16'h0000;
         default:    s = pfx ? SEED_PFX_FFFF : 16'hFFFF;
      endcase
      return s;
   endfunction

endpackage

[sv/rfcd_req_if.sv]
// Input channel: frame bytes and whitening table writes.
interface rfcd_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] data_byte;
   logic [5:0] table_index;
   logic       last_byte;

   modport source (output valid, cmd, data_byte, table_index, last_byte, input ready);
   modport sink   (input valid, cmd, data_byte, table_index, last_byte, output ready);
endinterface

[sv/rfcd_rsp_if.sv]
// Result channel: payload bytes and frame status.
interface rfcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic [1:0] frame_status;
   logic       last;

   modport source (output valid, kind, payload_byte, payload_index, frame_status, last,
                   input ready);
   modport sink   (input valid, kind, payload_byte, payload_index, frame_status, last,
                   output ready);
endinterface

[sv/rfcd_csr.sv]
// APB-style configuration registers.
module rfcd_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   output rfcd_pkg::cfg_type  cfg
);

   rfcd_pkg::cfg_type cfg_ff, cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[3:2];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            rfcd_pkg::REG_CRC_MODE:    cfg_in.crc_mode              = csr_pwdata[1:0];
            rfcd_pkg::REG_WHITEN_EN:   cfg_in.whiten_enable         = csr_pwdata[0];
            rfcd_pkg::REG_PAYLOAD_OFS: cfg_in.hdr_skip              = csr_pwdata[3:0];
            rfcd_pkg::REG_ADDR_PFX_EN: cfg_in.address_prefix_enable = csr_pwdata[0];
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         rfcd_pkg::REG_CRC_MODE:    csr_prdata = {30'd0, cfg_ff.crc_mode};
         rfcd_pkg::REG_WHITEN_EN:   csr_prdata = {31'd0, cfg_ff.whiten_enable};
         rfcd_pkg::REG_PAYLOAD_OFS: csr_prdata = {28'd0, cfg_ff.hdr_skip};
         rfcd_pkg::REG_ADDR_PFX_EN: csr_prdata = {31'd0, cfg_ff.address_prefix_enable};
         default:                   csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.crc_mode              <= rfcd_pkg::CRC_MODE_RESET;
         cfg_ff.whiten_enable         <= 1'b0;
         cfg_ff.hdr_skip              <= 4'd0;
         cfg_ff.address_prefix_enable <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/rfcd_front.sv]
// Front end: accepts items, tracks frame position, runs the CRC and builds queue entries.
module rfcd_front (
   input  logic               clock,
   input  logic               reset,
   rfcd_req_if.sink           req_chan,
   input  rfcd_pkg::cfg_type  cfg,
   input  logic               q_full,
   output logic               push,
   output rfcd_pkg::qent_type push_data
);

   logic [15:0] crc_ff, crc_in;
   logic [7:0]  pos_ff, pos_in;
   logic [7:0]  tail0_ff, tail0_in;
   logic [7:0]  tail1_ff, tail1_in;

   logic        accept, is_frame, is_table;
   logic [1:0]  trail;
   logic [15:0] seed, crc_base, crc_fed;
   logic [7:0]  off8, rel, pidx, raw, need8;
   logic        keep, in_pay, emit, tbl_ok;
   logic [1:0]  status;
   logic [7:0]  length;

   assign req_chan.ready = !q_full;
   assign accept   = req_chan.valid && req_chan.ready;
   assign is_frame = accept && (req_chan.cmd == rfcd_pkg::CMD_FRAME);
   assign is_table = accept && (req_chan.cmd == rfcd_pkg::CMD_TABLE);
   assign tbl_ok   = {3'b000, req_chan.table_index} < 9'(rfcd_pkg::WHITEN_DEPTH);

   always_comb begin
      case (cfg.crc_mode)
         rfcd_pkg::CRC_NONE: trail = 2'd0;
         rfcd_pkg::CRC_8:    trail = 2'd1;
         default:            trail = 2'd2;
      endcase
      seed     = rfcd_pkg::crc_seed(cfg.crc_mode, cfg.address_prefix_enable);
      off8     = {4'd0, cfg.hdr_skip};
      keep     = pos_ff < 8'(rfcd_pkg::MAX_FRAME_BYTES);
      crc_base = (pos_ff == 8'd0) ? seed : crc_ff;
      in_pay   = keep && (pos_ff >= off8);
      rel      = pos_ff - off8;
      emit     = in_pay && (rel >= {6'd0, trail});
      pidx     = rel - {6'd0, trail};
      case (trail)
         2'd2:    raw = tail1_ff;
         2'd1:    raw = tail0_ff;
         default: raw = req_chan.data_byte;
      endcase
      case (cfg.crc_mode)
         rfcd_pkg::CRC_NONE: crc_fed = crc_base;
         rfcd_pkg::CRC_8:    crc_fed = {8'h00, rfcd_pkg::crc8_byte(crc_base[7:0], raw)};
         default:            crc_fed = rfcd_pkg::ccitt_byte(crc_base, raw);
      endcase

      crc_in   = crc_ff;
      pos_in   = pos_ff;
      tail0_in = tail0_ff;
      tail1_in = tail1_ff;
      if (is_frame && keep) begin
         crc_in = emit ? crc_fed : crc_base;
         pos_in = pos_ff + 8'd1;
         if (in_pay) begin
            tail1_in = tail0_ff;
            tail0_in = req_chan.data_byte;
         end
      end

      // frame status from the state after this byte
      need8  = off8 + {6'd0, trail};
      length = 8'd0;
      if (pos_in < need8) begin
         status = rfcd_pkg::STAT_SHORT;
      end else begin
         length = pos_in - need8;
         case (trail)
            2'd0:    status = rfcd_pkg::STAT_OK;
            2'd1:    status = (crc_in[7:0] == tail0_in) ? rfcd_pkg::STAT_OK
                                                        : rfcd_pkg::STAT_CRC_BAD;
            default: status = (crc_in == {tail1_in, tail0_in}) ? rfcd_pkg::STAT_OK
                                                               : rfcd_pkg::STAT_CRC_BAD;
         endcase
      end

      push_data.is_write = is_table;
      push_data.has_pay  = !is_table && emit && keep;
      push_data.has_stat = !is_table && req_chan.last_byte;
      push_data.whiten   = cfg.whiten_enable && ({1'b0, pidx} < 9'(rfcd_pkg::WHITEN_DEPTH));
      push_data.value    = is_table ? req_chan.data_byte : raw;
      push_data.index    = is_table ? {2'b00, req_chan.table_index} : pidx;
      push_data.length   = length;
      push_data.status   = status;

      push = (is_table && tbl_ok)
          || (is_frame && ((emit && keep) || req_chan.last_byte));

      // close the frame
      if (is_frame && req_chan.last_byte) begin
         pos_in   = 8'd0;
         tail0_in = 8'd0;
         tail1_in = 8'd0;
         crc_in   = seed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= 16'd0;
         pos_ff   <= 8'd0;
         tail0_ff <= 8'd0;
         tail1_ff <= 8'd0;
      end else begin
         crc_ff   <= crc_in;
         pos_ff   <= pos_in;
         tail0_ff <= tail0_in;
         tail1_ff <= tail1_in;
      end
   end

endmodule

[sv/rfcd_queue.sv]
// Short FIFO of work entries between front and back end.
module rfcd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  rfcd_pkg::qent_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output rfcd_pkg::qent_type head_data
);

   rfcd_pkg::qent_type             slot_ff [rfcd_pkg::QUEUE_DEPTH];
   logic [rfcd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [rfcd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [rfcd_pkg::QCNT_W-1:0]    count_ff, count_in;

   localparam logic [rfcd_pkg::QPTR_W-1:0] LAST_PTR =
      rfcd_pkg::QPTR_W'(rfcd_pkg::QUEUE_DEPTH - 1);
   localparam logic [rfcd_pkg::QCNT_W-1:0] FULL_CNT = rfcd_pkg::QCNT_W'(rfcd_pkg::QUEUE_DEPTH);
   localparam logic [rfcd_pkg::QPTR_W-1:0] PTR_ONE  = rfcd_pkg::QPTR_W'(1);
   localparam logic [rfcd_pkg::QCNT_W-1:0] CNT_ONE  = rfcd_pkg::QCNT_W'(1);

   assign full       = count_ff == FULL_CNT;
   assign head_valid = count_ff != '0;
   assign head_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_ONE;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_ONE;
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_ONE;
      end else if (pop && !push) begin
         count_in = count_ff - CNT_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/rfcd_back.sv]
// Back end: whitening table, de-whitening and the result output register.
module rfcd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  rfcd_pkg::qent_type head_data,
   output logic               pop,
   rfcd_rsp_if.source         rsp_chan
);

   logic [7:0]                   whiten_mem [rfcd_pkg::WHITEN_DEPTH];
   logic [rfcd_pkg::WADDR_W-1:0] mem_addr;
   logic [7:0]                   rd_data_ff;

   rfcd_pkg::qent_type s1_ff;
   logic               s1_valid_ff, s1_valid_in;
   logic               phase_ff, phase_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_kind_ff, rsp_kind_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic [7:0]         rsp_index_ff, rsp_index_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic               rsp_last_ff, rsp_last_in;

   logic out_free, emit_any, emit_pay, s1_done;

   assign mem_addr = head_data.index[rfcd_pkg::WADDR_W-1:0];

   always_comb begin
      out_free = !rsp_valid_ff || rsp_chan.ready;
      emit_any = s1_valid_ff && out_free;
      emit_pay = s1_ff.has_pay && !phase_ff;
      // an entry with both results stays in s1 until its status is emitted
      s1_done  = emit_any && !(emit_pay && s1_ff.has_stat);
      pop      = head_valid && (!s1_valid_ff || s1_done);

      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      phase_in      = phase_ff;
      if (emit_any) begin
         rsp_valid_in = 1'b1;
         if (emit_pay) begin
            rsp_kind_in   = rfcd_pkg::KIND_PAYLOAD;
            rsp_byte_in   = s1_ff.value ^ (s1_ff.whiten ? rd_data_ff : 8'h00);
            rsp_index_in  = s1_ff.index;
            rsp_status_in = rfcd_pkg::STAT_OK;
            rsp_last_in   = !s1_ff.has_stat;
            phase_in      = s1_ff.has_stat;
         end else begin
            rsp_kind_in   = rfcd_pkg::KIND_STATUS;
            rsp_byte_in   = 8'h00;
            rsp_index_in  = s1_ff.length;
            rsp_status_in = s1_ff.status;
            rsp_last_in   = 1'b1;
            phase_in      = 1'b0;
         end
      end

      s1_valid_in = s1_valid_ff && !s1_done;
      if (pop) begin
         s1_valid_in = !head_data.is_write;
         phase_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff   <= rsp_kind_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
      if (pop) begin
         s1_ff <= head_data;
      end
   end

   // table writes and lookups happen in queue order, one entry per cycle unless the lookup stage holds its entry
   always_ff @(posedge clock) begin
      if (pop && head_data.is_write) begin
         whiten_mem[mem_addr] <= head_data.value;
      end
      if (pop) begin
         rd_data_ff <= whiten_mem[mem_addr];
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.payload_byte  = rsp_byte_ff;
   assign rsp_chan.payload_index = rsp_index_ff;
   assign rsp_chan.frame_status  = rsp_status_ff;
   assign rsp_chan.last          = rsp_last_ff;

endmodule

[sv/rx_frame_crc_dewhiten_checker_unit.sv]
// Received frame checker: CRC-8 / CCITT check, trailer strip, de-whitening and status.
//
// req_chan carries one item per handshake: a frame byte (with its last flag) or a
// whitening table write. rsp_chan returns payload byte results and, on the last
// byte of each frame, one status result (ok, CRC mismatch, too short) whose index
// is the payload length. The CRC trailer (one byte for CRC-8, two for CCITT) is
// held back and never emitted.
// The csr_ port is an APB-style register port; write it only while the block is idle.
//
// Path: a result that an item causes passes through the four-entry queue, the
// table lookup stage and the output register; a status that follows a payload
// byte of the same item is sent after that byte from the same lookup stage entry.
// Throughput: one item per cycle while the queue is not full; an item that yields
// both a payload byte and the frame status sends the two in turn through the single output register.
// When rsp_chan.ready is low the output holds, the queue fills, and req_chan.ready
// drops once the four queue entries are taken.
// Reset clears the frame position, delay line, queue and output; registers return
// to their defaults (CCITT seed FFFF). The whitening table is not cleared and must
// be loaded before de-whitening is enabled.
module rx_frame_crc_dewhiten_checker_unit (
   input  logic        clock,
   input  logic        reset,
   rfcd_req_if.sink    req_chan,
   rfcd_rsp_if.source  rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   rfcd_pkg::cfg_type  cfg;
   rfcd_pkg::qent_type push_data, head_data;
   logic               push, pop, q_full, head_valid;

   rfcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rfcd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .cfg       (cfg),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   rfcd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   rfcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

[sv/rfcd_checker.sv]
// Port-level checks on the result channel, bound to the top level.
module rfcd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_payload_byte,
   input logic [7:0] rsp_payload_index,
   input logic [1:0] rsp_frame_status,
   input logic       rsp_last
);

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_payload_byte) && $stable(rsp_payload_index)
         && $stable(rsp_frame_status) && $stable(rsp_last))
      else $error("result changed while stalled");

   a_stat_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |-> rsp_last && rsp_payload_byte == 8'h00
         && rsp_frame_status != 2'd3)
      else $error("malformed status result");

   a_pay_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_frame_status == 2'd0)
      else $error("payload result carries a status");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind rx_frame_crc_dewhiten_checker_unit rfcd_checker u_rfcd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_kind          (rsp_chan.kind),
   .rsp_payload_byte  (rsp_chan.payload_byte),
   .rsp_payload_index (rsp_chan.payload_index),
   .rsp_frame_status  (rsp_chan.frame_status),
   .rsp_last          (rsp_chan.last)
);
